>>> rtl/efd_pkg.sv
package efd_pkg;

   // Register indexes on the configuration port (word address)
   localparam logic [1:0] REG_HEAD_BYTE      = 2'd0;
   localparam logic [1:0] REG_TAIL_BYTE      = 2'd1;
   localparam logic [1:0] REG_ESCAPE_BYTE    = 2'd2;
   localparam logic [1:0] REG_PAYLOAD_LENGTH = 2'd3;

   // Frame status codes
   localparam logic [1:0] STATUS_NONE      = 2'd0;
   localparam logic [1:0] STATUS_GOOD      = 2'd1;
   localparam logic [1:0] STATUS_BAD_LEN   = 2'd2;
   localparam logic [1:0] STATUS_BAD_CKSUM = 2'd3;

   // Register reset values
   localparam logic [7:0] HEAD_BYTE_RESET      = 8'd170;
   localparam logic [7:0] TAIL_BYTE_RESET      = 8'd85;
   localparam logic [7:0] ESCAPE_BYTE_RESET    = 8'd165;
   localparam logic [7:0] PAYLOAD_LENGTH_RESET = 8'd16;

   typedef struct packed {
      logic [7:0] head_byte;
      logic [7:0] tail_byte;
      logic [7:0] escape_byte;
      logic [7:0] payload_length;
   } efd_cfg_type;

   typedef struct packed {
      logic       store_valid;
      logic [7:0] store_index;
      logic [7:0] store_byte;
      logic [1:0] frame_status;
      logic [7:0] frame_payload_len;
   } efd_result_type;

endpackage

>>> rtl/efd_step.sv
module efd_step
   import efd_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           accept,
   input  logic [7:0]     rx_byte,
   input  efd_cfg_type    cfg,
   output efd_result_type result
);

   logic [7:0] previous_byte_ff, previous_byte_in;
   logic       in_frame_ff, in_frame_in;
   logic       escape_pending_ff, escape_pending_in;
   logic [7:0] running_sum_ff, running_sum_in;
   logic [7:0] stored_count_ff, stored_count_in;
   logic [7:0] last_stored_ff, last_stored_in;
   logic [7:0] second_last_ff, second_last_in;

   logic       head_pair;
   logic       tail_pair;
   logic       overflow;
   logic       store;
   logic [7:0] check_sum;
   logic [7:0] payload_n;

   assign head_pair = (rx_byte == cfg.head_byte) && (previous_byte_ff == cfg.head_byte);
   assign tail_pair = (rx_byte == cfg.tail_byte) && (previous_byte_ff == cfg.tail_byte);
   // 9-bit compare so that a length near 255 does not wrap
   assign overflow  = {1'b0, stored_count_ff} > ({1'b0, cfg.payload_length} + 9'd2);
   assign check_sum = running_sum_ff - cfg.tail_byte - second_last_ff;
   assign payload_n = stored_count_ff - 8'd2;

   always_comb begin
      previous_byte_in  = previous_byte_ff;
      in_frame_in       = in_frame_ff;
      escape_pending_in = escape_pending_ff;
      running_sum_in    = running_sum_ff;
      stored_count_in   = stored_count_ff;
      last_stored_in    = last_stored_ff;
      second_last_in    = second_last_ff;
      result            = '0;
      store             = 1'b0;

      if (head_pair || overflow) begin
         running_sum_in   = '0;
         stored_count_in  = '0;
         in_frame_in      = 1'b1;
         previous_byte_in = rx_byte;
      end else if (tail_pair && in_frame_ff) begin
         previous_byte_in = rx_byte;
         in_frame_in      = 1'b0;
         running_sum_in   = '0;
         if (stored_count_ff < 8'd2) begin
            result.frame_status = STATUS_BAD_CKSUM;
         end else begin
            result.frame_payload_len = payload_n;
            if (check_sum != second_last_ff) begin
               result.frame_status = STATUS_BAD_CKSUM;
            end else if (payload_n == cfg.payload_length) begin
               result.frame_status = STATUS_GOOD;
            end else begin
               result.frame_status = STATUS_BAD_LEN;
            end
         end
      end else begin
         previous_byte_in = rx_byte;
         if (in_frame_ff) begin
            if (escape_pending_ff) begin
               store             = 1'b1;
               escape_pending_in = 1'b0;
               // escaped byte must not pair up as a marker
               previous_byte_in  = cfg.escape_byte;
            end else if (rx_byte == cfg.escape_byte) begin
               escape_pending_in = 1'b1;
            end else begin
               store = 1'b1;
            end
         end
         if (store) begin
            result.store_valid = 1'b1;
            result.store_index = stored_count_ff;
            result.store_byte  = rx_byte;
            stored_count_in    = stored_count_ff + 8'd1;
            running_sum_in     = running_sum_ff + rx_byte;
            second_last_in     = last_stored_ff;
            last_stored_in     = rx_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         previous_byte_ff  <= '0;
         in_frame_ff       <= 1'b0;
         escape_pending_ff <= 1'b0;
         running_sum_ff    <= '0;
         stored_count_ff   <= '0;
         last_stored_ff    <= '0;
         second_last_ff    <= '0;
      end else if (accept) begin
         previous_byte_ff  <= previous_byte_in;
         in_frame_ff       <= in_frame_in;
         escape_pending_ff <= escape_pending_in;
         running_sum_ff    <= running_sum_in;
         stored_count_ff   <= stored_count_in;
         last_stored_ff    <= last_stored_in;
         second_last_ff    <= second_last_in;
      end
   end

endmodule

>>> rtl/escaped_frame_deframer_core.sv
// Byte-stuffed frame deframer with an additive 8-bit checksum.
// Input channel (req_valid/req_ready/req_rx_byte): one received byte per
// transfer. Result channel (rsp_valid/rsp_ready/rsp_*): exactly one result
// per input byte, in order: a store report (index and byte) for payload
// bytes, a frame status with payload length at the closing tail pair, or
// an empty result (no store, status none) for every other byte.
// Throughput: one byte per cycle while req_ready is high; deframing is
// one pass of compares and 8-bit sums into the registered output stage.
// Stall: a two-entry output stage (result register plus skid register)
// lets one more byte transfer while a result waits; req_ready drops only
// when both entries are full, and rises again once rsp_ready has taken one.
// Reset (synchronous, active high): deframer state cleared (not in frame),
// both output entries empty, registers back to head 170, tail 85,
// escape 165, payload length 16.
// APB port: four 8-bit registers at byte addresses 0, 4, 8, 12; pready is
// always high; write only while the block is idle.
module escaped_frame_deframer_core
   import efd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_store_valid,
   output logic [7:0]  rsp_store_index,
   output logic [7:0]  rsp_store_byte,
   output logic [1:0]  rsp_frame_status,
   output logic [7:0]  rsp_frame_payload_len,

   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   // ---- configuration registers ----
   efd_cfg_type cfg_ff;
   logic        csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.head_byte      <= HEAD_BYTE_RESET;
         cfg_ff.tail_byte      <= TAIL_BYTE_RESET;
         cfg_ff.escape_byte    <= ESCAPE_BYTE_RESET;
         cfg_ff.payload_length <= PAYLOAD_LENGTH_RESET;
      end else if (csr_write) begin
         unique case (paddr[3:2])
            REG_HEAD_BYTE:      cfg_ff.head_byte      <= pwdata[7:0];
            REG_TAIL_BYTE:      cfg_ff.tail_byte      <= pwdata[7:0];
            REG_ESCAPE_BYTE:    cfg_ff.escape_byte    <= pwdata[7:0];
            REG_PAYLOAD_LENGTH: cfg_ff.payload_length <= pwdata[7:0];
            default:            cfg_ff                <= cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         REG_HEAD_BYTE:      prdata = {24'd0, cfg_ff.head_byte};
         REG_TAIL_BYTE:      prdata = {24'd0, cfg_ff.tail_byte};
         REG_ESCAPE_BYTE:    prdata = {24'd0, cfg_ff.escape_byte};
         REG_PAYLOAD_LENGTH: prdata = {24'd0, cfg_ff.payload_length};
         default:            prdata = '0;
      endcase
   end

   // ---- deframer ----
   logic           in_xfer;
   logic           out_xfer;
   efd_result_type step_result;

   assign in_xfer  = req_valid && req_ready;
   assign out_xfer = rsp_valid && rsp_ready;

   efd_step u_step (
      .clock   (clock),
      .reset   (reset),
      .accept  (in_xfer),
      .rx_byte (req_rx_byte),
      .cfg     (cfg_ff),
      .result  (step_result)
   );

   // ---- output stage: result register plus skid register ----
   logic           out_valid_ff, out_valid_in;
   efd_result_type out_data_ff, out_data_in;
   logic           skid_valid_ff, skid_valid_in;
   efd_result_type skid_data_ff, skid_data_in;

   // skid empty means at most one result is held, so one more fits
   assign req_ready = !skid_valid_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || out_xfer) begin
         // result register frees up: refill from skid first, then new byte
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = in_xfer;
            skid_data_in  = step_result;
         end else begin
            out_valid_in = in_xfer;
            out_data_in  = step_result;
         end
      end else if (in_xfer) begin
         // receiver stalled: park the new result
         skid_valid_in = 1'b1;
         skid_data_in  = step_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid             = out_valid_ff;
   assign rsp_store_valid       = out_data_ff.store_valid;
   assign rsp_store_index       = out_data_ff.store_index;
   assign rsp_store_byte        = out_data_ff.store_byte;
   assign rsp_frame_status      = out_data_ff.frame_status;
   assign rsp_frame_payload_len = out_data_ff.frame_payload_len;

endmodule
